[sv/blp_pkg.sv]
// Package for the banked LED PWM driver: shared types, codes and constants.
// Used by every module of the block but the checker; depends on nothing.
package blp_pkg;

	typedef enum logic [1:0] {
		CMD_TICK  = 2'd0,
		CMD_WRITE = 2'd1,
		CMD_WAKE  = 2'd2,
		CMD_CLEAR = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		CFG_PERIOD   = 2'd0,
		CFG_DEBOUNCE = 2'd1,
		CFG_LONG     = 2'd2,
		CFG_HIGHEST  = 2'd3
	} cfg_idx_t;

	localparam int NumChan = 3;
	localparam int NumBank = 3;

	typedef logic [NumChan-1:0][7:0] lvl3_t;

	// Bank numbers; bank one drives its channels active low.
	localparam logic [1:0] BANK_A = 2'd0;
	localparam logic [1:0] BANK_B = 2'd1;
	localparam logic [1:0] BANK_C = 2'd2;

	localparam logic [1:0] SLOT_SAMPLE = 2'd3;

	localparam logic [4:0] DIR_AB    = 5'h17;
	localparam logic [4:0] DIR_C     = 5'h1B;
	localparam logic [4:0] LEVEL_AC  = 5'h13;
	localparam logic [4:0] LEVEL_B   = 5'h1F;

	// Pin driven by each channel of a bank.
	localparam logic [NumChan-1:0][4:0] CHAN_BIT = {5'h10, 5'h02, 5'h01};

	localparam logic [7:0] PERIOD_RST   = 8'd20;
	localparam logic [6:0] DEBOUNCE_RST = 7'd5;
	localparam logic [6:0] LONG_RST     = 7'd100;
	localparam logic [3:0] HIGHEST_RST  = 4'd12;

	localparam logic [6:0] PRESS_MAX = 7'd127;
	localparam logic [3:0] MODE_RST  = 4'd1;

	// Control from the accepted item to the button and frame logic.
	typedef struct packed {
		logic sample;
		logic pressed;
		logic wake;
		logic clear;
	} btn_ctl_t;

endpackage

[sv/blp_store.sv]
// Brightness store for nine LEDs, kept as three lanes of three rows.
// Depends on blp_pkg. Each lane is read at the row of the current bank.
module blp_store (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                wr_en,
	input  logic [3:0]          wr_index,
	input  logic [7:0]          wr_data,
	input  logic [1:0]          rd_bank,
	output blp_pkg::lvl3_t      rd_levels
);

	logic [blp_pkg::NumBank-1:0][blp_pkg::NumChan-1:0][7:0] lvl_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lvl_q <= '0;
		end else if (wr_en) begin
			for (int r = 0; r < blp_pkg::NumBank; r++) begin
				for (int c = 0; c < blp_pkg::NumChan; c++) begin
					if (wr_index == 4'(r * blp_pkg::NumChan + c)) begin
						lvl_q[r][c] <= wr_data;
					end
				end
			end
		end
	end

	always_comb begin
		case (rd_bank)
			blp_pkg::BANK_A: rd_levels = lvl_q[0];
			blp_pkg::BANK_B: rd_levels = lvl_q[1];
			blp_pkg::BANK_C: rd_levels = lvl_q[2];
			default:         rd_levels = '0;
		endcase
	end

endmodule

[sv/blp_pwm.sv]
// PWM counter, compare latch and bank sequencer for the LED driver.
// Depends on blp_pkg; reads brightness from blp_store through rd_levels.
module blp_pwm (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           tick,
	input  logic [7:0]     period,
	input  blp_pkg::lvl3_t levels,
	output logic [1:0]     bank,
	output logic [4:0]     res_dir,
	output logic [4:0]     res_level,
	output logic           sample
);

	blp_pkg::lvl3_t cmp_q;
	blp_pkg::lvl3_t cmp_nxt;
	logic [7:0]     pos_q;
	logic [1:0]     slot_q;
	logic [1:0]     bank_q;
	logic [4:0]     base_level_q;
	logic [4:0]     next_level_q;
	logic [4:0]     next_dir_q;

	logic [4:0]     level_nxt;
	logic [8:0]     cnt;
	logic           wrap;
	logic [1:0]     slot_eff;
	logic [4:0]     dir_nxt;
	logic [1:0]     bank_nxt;
	logic [4:0]     base_nxt;

	always_comb begin
		cmp_nxt   = cmp_q;
		level_nxt = next_level_q;
		if (pos_q == 8'd0) begin
			for (int i = 0; i < blp_pkg::NumChan; i++) begin
				if (bank_q == blp_pkg::BANK_B) begin
					cmp_nxt[i] = period - levels[i] - 8'd1;
				end else begin
					cmp_nxt[i] = levels[i];
				end
			end
			level_nxt = base_level_q;
		end
		for (int i = 0; i < blp_pkg::NumChan; i++) begin
			if (cmp_nxt[i] == pos_q) begin
				level_nxt = level_nxt & ~blp_pkg::CHAN_BIT[i];
			end
		end

		cnt  = {1'b0, pos_q} + 9'd1;
		wrap = (cnt >= {1'b0, period});

		// The sampling slot falls straight through to the first bank.
		sample   = wrap && (slot_q == blp_pkg::SLOT_SAMPLE);
		slot_eff = (slot_q == blp_pkg::SLOT_SAMPLE) ? 2'd0 : slot_q;

		case (slot_eff)
			2'd1: begin
				dir_nxt  = blp_pkg::DIR_AB;
				bank_nxt = blp_pkg::BANK_B;
				base_nxt = blp_pkg::LEVEL_B;
			end
			2'd2: begin
				dir_nxt  = blp_pkg::DIR_C;
				bank_nxt = blp_pkg::BANK_C;
				base_nxt = blp_pkg::LEVEL_AC;
			end
			default: begin
				dir_nxt  = blp_pkg::DIR_AB;
				bank_nxt = blp_pkg::BANK_A;
				base_nxt = blp_pkg::LEVEL_AC;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmp_q        <= '0;
			pos_q        <= '0;
			slot_q       <= '0;
			bank_q       <= blp_pkg::BANK_A;
			base_level_q <= blp_pkg::LEVEL_AC;
			next_level_q <= blp_pkg::LEVEL_AC;
			next_dir_q   <= '0;
		end else if (tick) begin
			cmp_q        <= cmp_nxt;
			next_level_q <= level_nxt;
			if (wrap) begin
				pos_q        <= '0;
				slot_q       <= slot_eff + 2'd1;
				next_dir_q   <= dir_nxt;
				bank_q       <= bank_nxt;
				base_level_q <= base_nxt;
			end else begin
				pos_q <= cnt[7:0];
			end
		end
	end

	assign bank      = bank_q;
	assign res_dir   = next_dir_q;
	assign res_level = next_level_q;

endmodule

[sv/blp_button.sv]
// Button debounce, mode selection, shutdown flag and frame counter.
// Depends on blp_pkg; driven by the sample strobe from blp_pwm.
module blp_button (
	input  logic               clk,
	input  logic               arst_n,
	input  blp_pkg::btn_ctl_t  ctl,
	input  logic [6:0]         debounce_min,
	input  logic [6:0]         long_press,
	input  logic [3:0]         highest_mode,
	output logic [3:0]         mode_nxt,
	output logic               shutdown_nxt,
	output logic [15:0]        frame_nxt
);

	logic [6:0]  press_q;
	logic [3:0]  mode_q;
	logic        shutdown_q;
	logic [15:0] frame_q;
	logic [6:0]  press_nxt;

	always_comb begin
		press_nxt    = press_q;
		mode_nxt     = mode_q;
		shutdown_nxt = shutdown_q;
		frame_nxt    = frame_q;
		if (ctl.sample) begin
			frame_nxt = frame_q + 16'd1;
			if (ctl.pressed) begin
				if (press_q == long_press) begin
					shutdown_nxt = 1'b1;
				end
				if (press_q < blp_pkg::PRESS_MAX) begin
					press_nxt = press_q + 7'd1;
				end
			end else begin
				// A short press that cleared the debounce window steps the mode.
				if (press_q > debounce_min && press_q <= long_press) begin
					mode_nxt = (mode_q >= highest_mode) ? blp_pkg::MODE_RST
					                                    : mode_q + 4'd1;
				end
				press_nxt = '0;
			end
		end
		if (ctl.wake) begin
			shutdown_nxt = 1'b0;
			press_nxt    = long_press + 7'd1;
		end
		if (ctl.clear) begin
			frame_nxt = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			press_q    <= '0;
			mode_q     <= blp_pkg::MODE_RST;
			shutdown_q <= 1'b0;
			frame_q    <= '0;
		end else begin
			press_q    <= press_nxt;
			mode_q     <= mode_nxt;
			shutdown_q <= shutdown_nxt;
			frame_q    <= frame_nxt;
		end
	end

endmodule

[sv/banked_led_pwm_with_button.sv]
// Top level of the banked LED PWM driver with push button.
// Depends on blp_pkg, blp_store, blp_pwm and blp_button.
//
// Usage: every item on the input channel (cmd, led_index, brightness,
// button_low) is accepted when in_valid is high and in_stall is low, and
// yields exactly one result on the output channel, valid while out_valid is
// high and taken when out_stall is low. A timer tick returns the pin
// direction and level computed on the previous tick; other commands return
// zero pins. Mode, shutdown flag and frame count reflect the state after
// the item. All state is updated at acceptance and the result is captured
// in one output register, and one item is accepted every cycle while
// in_stall is low. The output register is the only stage: in_stall
// rises only while a result is held and out_stall is high, and a new item
// is taken in the same cycle the held result is taken.
// Configuration is written through cfg_valid/cfg_ready (always ready) with
// cfg_index selecting period, debounce minimum, long press and highest mode;
// write it only while the block is idle. Reset clears the brightness store
// and all counters, restores register defaults and sets mode to one.
module banked_led_pwm_with_button (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  cmd,
	input  logic [3:0]  led_index,
	input  logic [7:0]  brightness,
	input  logic        button_low,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [4:0]  pin_dir,
	output logic [4:0]  pin_level,
	output logic        button_sampled,
	output logic [3:0]  mode,
	output logic        shutdown_request,
	output logic [15:0] frame_count,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data
);

	logic [7:0] period_q;
	logic [6:0] debounce_q;
	logic [6:0] long_q;
	logic [3:0] highest_q;

	logic       accept;
	logic       is_tick;
	logic       is_write;
	logic       sample;
	logic [1:0] bank;
	logic [4:0] res_dir;
	logic [4:0] res_level;
	logic [3:0] mode_nxt;
	logic       shutdown_nxt;
	logic [15:0] frame_nxt;

	blp_pkg::lvl3_t    levels;
	blp_pkg::btn_ctl_t ctl;

	logic        out_valid_q;
	logic [4:0]  dir_q;
	logic [4:0]  level_q;
	logic        sampled_q;
	logic [3:0]  mode_q;
	logic        shutdown_q;
	logic [15:0] frame_q;

	assign in_stall  = out_valid_q & out_stall;
	assign accept    = in_valid & ~in_stall;
	assign is_tick   = accept && (blp_pkg::cmd_t'(cmd) == blp_pkg::CMD_TICK);
	assign is_write  = accept && (blp_pkg::cmd_t'(cmd) == blp_pkg::CMD_WRITE);
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q   <= blp_pkg::PERIOD_RST;
			debounce_q <= blp_pkg::DEBOUNCE_RST;
			long_q     <= blp_pkg::LONG_RST;
			highest_q  <= blp_pkg::HIGHEST_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (blp_pkg::cfg_idx_t'(cfg_index))
				blp_pkg::CFG_PERIOD:   period_q   <= cfg_data;
				blp_pkg::CFG_DEBOUNCE: debounce_q <= cfg_data[6:0];
				blp_pkg::CFG_LONG:     long_q     <= cfg_data[6:0];
				blp_pkg::CFG_HIGHEST:  highest_q  <= cfg_data[3:0];
				default:               period_q   <= period_q;
			endcase
		end
	end

	blp_store u_store (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (is_write),
		.wr_index  (led_index),
		.wr_data   (brightness),
		.rd_bank   (bank),
		.rd_levels (levels)
	);

	blp_pwm u_pwm (
		.clk       (clk),
		.arst_n    (arst_n),
		.tick      (is_tick),
		.period    (period_q),
		.levels    (levels),
		.bank      (bank),
		.res_dir   (res_dir),
		.res_level (res_level),
		.sample    (sample)
	);

	always_comb begin
		ctl.sample  = is_tick & sample;
		ctl.pressed = button_low;
		ctl.wake    = accept && (blp_pkg::cmd_t'(cmd) == blp_pkg::CMD_WAKE);
		ctl.clear   = accept && (blp_pkg::cmd_t'(cmd) == blp_pkg::CMD_CLEAR);
	end

	blp_button u_button (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl          (ctl),
		.debounce_min (debounce_q),
		.long_press   (long_q),
		.highest_mode (highest_q),
		.mode_nxt     (mode_nxt),
		.shutdown_nxt (shutdown_nxt),
		.frame_nxt    (frame_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			dir_q      <= is_tick ? res_dir : 5'd0;
			level_q    <= is_tick ? res_level : 5'd0;
			sampled_q  <= ctl.sample;
			mode_q     <= mode_nxt;
			shutdown_q <= shutdown_nxt;
			frame_q    <= frame_nxt;
		end
	end

	assign out_valid        = out_valid_q;
	assign pin_dir          = dir_q;
	assign pin_level        = level_q;
	assign button_sampled   = sampled_q;
	assign mode             = mode_q;
	assign shutdown_request = shutdown_q;
	assign frame_count      = frame_q;

endmodule

[sv/blp_checker.sv]
// Port-level checks for the banked LED PWM driver, bound to the top level.
// Depends only on the top level's ports.
module blp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [15:0] frame_count
);

	// A held result that is stalled blocks the input side.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |-> in_stall)
		else $error("held result stalled but input not stalled");

	// Every accepted item produces a result in the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> out_valid)
		else $error("accepted item produced no result");

	// A taken result with nothing new behind it leaves the output empty.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !(in_valid && !in_stall) |=> !out_valid)
		else $error("result repeated without a new item");

	// Frame count only moves when an item is accepted.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !(in_valid && !in_stall) |=> $stable(frame_count))
		else $error("frame count changed without an item");

endmodule

bind banked_led_pwm_with_button blp_checker u_blp_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_stall    (in_stall),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.frame_count (frame_count)
);
